// ===== design/nef_pkg.sv =====
`default_nettype none
package nef_pkg;

   localparam int unsigned MAX_CODE_BYTES = 4;
   localparam int unsigned AFFIX_CHARS    = 8;
   localparam int unsigned DEC_DIGITS     = 10;
   localparam int unsigned CONV_STEPS     = 32;

   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] TAG_UNICODE = 8'd1;
   localparam logic [7:0] TAG_BYTE    = 8'd3;

   // Register indexes on the configuration port.
   localparam logic [2:0] CSR_PREFIX_BYTES  = 3'd0;
   localparam logic [2:0] CSR_PREFIX_LENGTH = 3'd1;
   localparam logic [2:0] CSR_SUFFIX_BYTES  = 3'd2;
   localparam logic [2:0] CSR_SUFFIX_LENGTH = 3'd3;
   localparam logic [2:0] CSR_RADIX_MODE    = 3'd4;
   localparam logic [2:0] CSR_FILTER_KIND   = 3'd5;

   localparam logic [1:0] RADIX_HEX = 2'd0;
   localparam logic [1:0] RADIX_DEC = 2'd1;
   localparam logic [1:0] RADIX_OCT = 2'd2;

   localparam logic FILTER_UNICODE = 1'b0;
   localparam logic FILTER_BYTE    = 1'b1;

   typedef struct packed {
      logic [7:0]  tag_byte;
      logic [2:0]  byte_count;
      logic [31:0] code_value;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       last_char;
      logic       status;
   } rsp_type;

   typedef enum logic [1:0] {
      PH_PREFIX,
      PH_DIGIT,
      PH_SUFFIX,
      PH_DEAD
   } phase_type;

   typedef enum logic [1:0] {
      DM_HEX,
      DM_OCT,
      DM_DEC
   } digit_mode_type;

   typedef struct packed {
      logic       load;
      logic       emit;
      phase_type  phase;
      logic [3:0] index;
      logic       last;
   } cmd_type;

   typedef struct packed {
      logic       dead;
      logic [3:0] pre_len;
      logic [3:0] suf_len;
      logic [3:0] dig_len;
      logic       digits_ready;
      logic       out_free;
   } sts_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] ch;
      if (nib < 4'd10) begin
         ch = CHAR_ZERO + {4'd0, nib};
      end else begin
         ch = 8'h41 + {4'd0, nib - 4'd10};
      end
      return ch;
   endfunction

endpackage
`default_nettype wire

// ===== design/numeric_escape_formatter_top.sv =====
`default_nettype none
// Numeric escape formatter. Each request transaction carries a tag byte, a byte count and a
// big-endian code value; the block answers with one response transaction per output character:
// the configured prefix, the digits of the value (hexadecimal, decimal or octal, depending on
// the filter and radix registers) and the configured suffix, with last_char set on the final
// character. A request that the filter rejects, or whose radix the filter cannot serve, gives
// a single dead-end response with out_char zero and status set. One request is processed at a
// time. The prefix and suffix lengths are at most eight characters each. Decimal digits come
// from a 32-step shift-and-add-3 converter that starts at acceptance and runs while the prefix
// is sent. The next request is accepted in the cycle after the last character has been loaded
// into the output register, even while that character still waits to be taken. Registers are
// written through the csr_ port; the user must write them only while the block is idle, which
// the block itself does not enforce, and writes then take effect on the next request.
module numeric_escape_formatter_top (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire nef_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output nef_pkg::rsp_type      rsp_data,
   input  wire logic             csr_write_en,
   input  wire logic [2:0]       csr_index,
   input  wire logic [63:0]      csr_wdata
);

   // Command and status buses between the controller and the datapath.
   nef_pkg::cmd_type cmd;
   nef_pkg::sts_type sts;

   // The controller walks the prefix, digit and suffix phases and issues one character
   // load per cycle whenever the output register is free and, in the digit phase, the digits are ready.
   nef_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds the registers, classifies the transaction, converts the value and
   // drives the output register.
   nef_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_data     (req_data),
      .cmd          (cmd),
      .sts          (sts),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );

   // A dead-end response is always the single, final character of its transaction.
   a_dead_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status) |-> (rsp_data.last_char && rsp_data.out_char == 8'd0))
      else $error("dead-end response without last_char or with nonzero character");

   // Once a request is accepted, no further request is taken in the next cycle.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while another is in progress");

   // A character is only loaded into the output register when it is free.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !cmd.emit)
      else $error("stalled response overwritten");

endmodule
`default_nettype wire

// ===== design/nef_ctrl.sv =====
`default_nettype none
module nef_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire nef_pkg::sts_type sts,
   output nef_pkg::cmd_type     cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_PREFIX,
      ST_DIGITS,
      ST_SUFFIX,
      ST_DEAD
   } state_type;

   state_type  state_ff, state_in;
   logic [3:0] idx_ff, idx_in;

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      req_ready = 1'b0;
      cmd.load  = 1'b0;
      cmd.emit  = 1'b0;
      cmd.phase = nef_pkg::PH_DEAD;
      cmd.index = idx_ff;
      cmd.last  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               idx_in   = 4'd0;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            idx_in = 4'd0;
            if (sts.dead) begin
               state_in = ST_DEAD;
            end else if (sts.pre_len != 4'd0) begin
               state_in = ST_PREFIX;
            end else begin
               state_in = ST_DIGITS;
            end
         end
         ST_PREFIX: begin
            cmd.phase = nef_pkg::PH_PREFIX;
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (idx_ff == sts.pre_len - 4'd1) begin
                  idx_in   = 4'd0;
                  state_in = ST_DIGITS;
               end else begin
                  idx_in = idx_ff + 4'd1;
               end
            end
         end
         ST_DIGITS: begin
            cmd.phase = nef_pkg::PH_DIGIT;
            cmd.last  = (idx_ff == sts.dig_len - 4'd1) && (sts.suf_len == 4'd0);
            if (sts.out_free && sts.digits_ready) begin
               cmd.emit = 1'b1;
               if (idx_ff == sts.dig_len - 4'd1) begin
                  idx_in   = 4'd0;
                  state_in = (sts.suf_len == 4'd0) ? ST_IDLE : ST_SUFFIX;
               end else begin
                  idx_in = idx_ff + 4'd1;
               end
            end
         end
         ST_SUFFIX: begin
            cmd.phase = nef_pkg::PH_SUFFIX;
            cmd.last  = (idx_ff == sts.suf_len - 4'd1);
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (idx_ff == sts.suf_len - 4'd1) begin
                  idx_in   = 4'd0;
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 4'd1;
               end
            end
         end
         ST_DEAD: begin
            cmd.phase = nef_pkg::PH_DEAD;
            cmd.last  = 1'b1;
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= 4'd0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/nef_datapath.sv =====
`default_nettype none
module nef_datapath (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_write_en,
   input  wire logic [2:0]       csr_index,
   input  wire logic [63:0]      csr_wdata,
   input  wire nef_pkg::req_type req_data,
   input  wire nef_pkg::cmd_type cmd,
   output nef_pkg::sts_type      sts,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output nef_pkg::rsp_type      rsp_data
);

   // Configuration registers.
   logic [63:0] prefix_bytes_ff;
   logic [3:0]  prefix_length_ff;
   logic [63:0] suffix_bytes_ff;
   logic [3:0]  suffix_length_ff;
   logic [1:0]  radix_mode_ff;
   logic        filter_kind_ff;

   // Per-transaction working registers.
   logic [31:0]             value_ff, value_in;
   logic                    dead_ff, dead_in;
   nef_pkg::digit_mode_type mode_ff, mode_in;
   logic [3:0]              fix_len_ff, fix_len_in;

   // Binary to BCD shift-and-add-3 converter.
   logic [31:0] shift_ff, shift_in;
   logic [39:0] bcd_ff, bcd_in;
   logic [5:0]  conv_cnt_ff, conv_cnt_in;
   logic [39:0] bcd_adj;
   logic [3:0]  dec_len;

   logic           rsp_valid_ff;
   nef_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic        unicode_ok;
   logic        byte_ok;
   logic [3:0]  dig_len;
   logic [3:0]  digit_pos;
   logic [7:0]  digit_char;

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_bytes_ff  <= 64'd37;
         prefix_length_ff <= 4'd1;
         suffix_bytes_ff  <= 64'd0;
         suffix_length_ff <= 4'd0;
         radix_mode_ff    <= nef_pkg::RADIX_HEX;
         filter_kind_ff   <= nef_pkg::FILTER_UNICODE;
      end else if (csr_write_en) begin
         case (csr_index)
            nef_pkg::CSR_PREFIX_BYTES:  prefix_bytes_ff  <= csr_wdata;
            nef_pkg::CSR_PREFIX_LENGTH: prefix_length_ff <= csr_wdata[3:0];
            nef_pkg::CSR_SUFFIX_BYTES:  suffix_bytes_ff  <= csr_wdata;
            nef_pkg::CSR_SUFFIX_LENGTH: suffix_length_ff <= csr_wdata[3:0];
            nef_pkg::CSR_RADIX_MODE:    radix_mode_ff    <= csr_wdata[1:0];
            nef_pkg::CSR_FILTER_KIND:   filter_kind_ff   <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Classification of an incoming transaction.
   always_comb begin
      case (req_data.byte_count)
         3'd1:    value_in = {24'd0, req_data.code_value[7:0]};
         3'd2:    value_in = {16'd0, req_data.code_value[15:0]};
         3'd3:    value_in = {8'd0, req_data.code_value[23:0]};
         3'd4:    value_in = req_data.code_value;
         default: value_in = 32'd0;
      endcase
      unicode_ok = (filter_kind_ff == nef_pkg::FILTER_UNICODE)
                   && (req_data.tag_byte == nef_pkg::TAG_UNICODE)
                   && (req_data.byte_count >= 3'd1)
                   && (req_data.byte_count <= 3'(nef_pkg::MAX_CODE_BYTES));
      byte_ok = (filter_kind_ff == nef_pkg::FILTER_BYTE)
                && (req_data.tag_byte == nef_pkg::TAG_BYTE)
                && (req_data.byte_count == 3'd1);
      dead_in    = 1'b1;
      mode_in    = nef_pkg::DM_HEX;
      fix_len_in = 4'd2;
      if (unicode_ok) begin
         if (radix_mode_ff == nef_pkg::RADIX_HEX) begin
            dead_in    = 1'b0;
            fix_len_in = {req_data.byte_count, 1'b0};
         end else if (radix_mode_ff == nef_pkg::RADIX_DEC) begin
            dead_in = 1'b0;
            mode_in = nef_pkg::DM_DEC;
         end
      end else if (byte_ok) begin
         if (radix_mode_ff == nef_pkg::RADIX_OCT) begin
            dead_in    = 1'b0;
            mode_in    = nef_pkg::DM_OCT;
            fix_len_in = 4'd3;
         end else if (radix_mode_ff == nef_pkg::RADIX_DEC) begin
            dead_in = 1'b0;
            mode_in = nef_pkg::DM_DEC;
         end else if (radix_mode_ff == nef_pkg::RADIX_HEX) begin
            dead_in = 1'b0;
         end
      end
   end

   always_comb begin
      for (int d = 0; d < nef_pkg::DEC_DIGITS; d++) begin
         if (bcd_ff[4*d +: 4] >= 4'd5) begin
            bcd_adj[4*d +: 4] = bcd_ff[4*d +: 4] + 4'd3;
         end else begin
            bcd_adj[4*d +: 4] = bcd_ff[4*d +: 4];
         end
      end
      if (cmd.load) begin
         shift_in    = value_in;
         bcd_in      = 40'd0;
         conv_cnt_in = 6'(nef_pkg::CONV_STEPS);
      end else if (conv_cnt_ff != 6'd0) begin
         shift_in    = {shift_ff[30:0], 1'b0};
         bcd_in      = {bcd_adj[38:0], shift_ff[31]};
         conv_cnt_in = conv_cnt_ff - 6'd1;
      end else begin
         shift_in    = shift_ff;
         bcd_in      = bcd_ff;
         conv_cnt_in = conv_cnt_ff;
      end
   end

   always_comb begin
      dec_len = 4'd1;
      for (int d = 0; d < nef_pkg::DEC_DIGITS; d++) begin
         if (bcd_ff[4*d +: 4] != 4'd0) begin
            dec_len = 4'(d + 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         conv_cnt_ff <= 6'd0;
      end else begin
         conv_cnt_ff <= conv_cnt_in;
      end
      shift_ff <= shift_in;
      bcd_ff   <= bcd_in;
      if (cmd.load) begin
         value_ff   <= value_in;
         dead_ff    <= dead_in;
         mode_ff    <= mode_in;
         fix_len_ff <= fix_len_in;
      end
   end

   assign dig_len   = (mode_ff == nef_pkg::DM_DEC) ? dec_len : fix_len_ff;
   assign digit_pos = dig_len - 4'd1 - cmd.index;

   always_comb begin
      case (mode_ff)
         nef_pkg::DM_HEX: digit_char = nef_pkg::hex_char(value_ff[4*digit_pos[2:0] +: 4]);
         nef_pkg::DM_OCT: digit_char = nef_pkg::CHAR_ZERO
                                       + {5'd0, value_ff[3*digit_pos[1:0] +: 3]};
         nef_pkg::DM_DEC: digit_char = nef_pkg::CHAR_ZERO + {4'd0, bcd_ff[4*digit_pos +: 4]};
         default:         digit_char = 8'd0;
      endcase
   end

   always_comb begin
      rsp_data_in.last_char = cmd.last;
      rsp_data_in.status    = 1'b0;
      case (cmd.phase)
         nef_pkg::PH_PREFIX: rsp_data_in.out_char = prefix_bytes_ff[8*cmd.index[2:0] +: 8];
         nef_pkg::PH_DIGIT:  rsp_data_in.out_char = digit_char;
         nef_pkg::PH_SUFFIX: rsp_data_in.out_char = suffix_bytes_ff[8*cmd.index[2:0] +: 8];
         default: begin
            rsp_data_in.out_char = 8'd0;
            rsp_data_in.status   = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      sts.dead         = dead_ff;
      sts.pre_len      = (prefix_length_ff > 4'(nef_pkg::AFFIX_CHARS))
                         ? 4'(nef_pkg::AFFIX_CHARS) : prefix_length_ff;
      sts.suf_len      = (suffix_length_ff > 4'(nef_pkg::AFFIX_CHARS))
                         ? 4'(nef_pkg::AFFIX_CHARS) : suffix_length_ff;
      sts.dig_len      = dig_len;
      sts.digits_ready = (mode_ff != nef_pkg::DM_DEC) || (conv_cnt_ff == 6'd0);
      sts.out_free     = !rsp_valid_ff || rsp_ready;
   end

endmodule
`default_nettype wire
